### rtl/lccf_pkg.sv
// Shared constants and types for the light-cone crossing finder.
package lccf_pkg;

    localparam int NumImages      = 8;
    localparam int MaxCrossings   = 8;
    localparam int FracBits       = 30;
    localparam int ImgW           = 3;
    localparam int SqrtShift      = 2 * (FracBits - 16);
    localparam int SumW           = 66;

    localparam logic [31:0] InvIntervalReset = 32'd65536;
    localparam logic [0:0]  AddrInvInterval  = 1'b0;

    // Input payload, 288 bits: start x,y,z, end x,y,z, time, length, inverse length.
    typedef struct packed {
        logic [31:0] step_length_inverse;
        logic [31:0] step_length;
        logic [31:0] step_time;
        logic signed [31:0] end_z;
        logic signed [31:0] end_y;
        logic signed [31:0] end_x;
        logic signed [31:0] start_z;
        logic signed [31:0] start_y;
        logic signed [31:0] start_x;
    } in_item_t;

    // Output payload: slice, image, positions, velocities.
    typedef struct packed {
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [ImgW-1:0]    image_number;
        logic [15:0]        slice_index;
    } out_item_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh07FFFFFFF)
            r = 32'h7FFFFFFF;
        else if (v < -34'sh080000000)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/lccf_sqrt.sv
// Digit-serial integer square root, one result bit per cycle.
module lccf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import lccf_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] res_reg, res_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        res_next  = res_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            bit_next  = 64'h4000000000000000;
            res_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

### rtl/lccf_serial_mul.sv
// Shift-and-add multiplier, 34 x 32 unsigned, one multiplier bit per cycle.
module lccf_serial_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] mcand,
    input  logic [31:0] mplier,
    output logic        done,
    output logic [65:0] product
);
    import lccf_pkg::*;

    logic [65:0] acc_reg, acc_next;
    logic [65:0] mc_reg, mc_next;
    logic [31:0] mp_reg, mp_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = {32'd0, mcand};
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

### rtl/light_cone_crossing_finder_core.sv
// Top level of the light-cone crossing finder: sequencer, shared serial units, output register.
//
//  channel | dir | transfer condition         | payload
//  s_*     | in  | s_tvalid & s_tready        | particle step (288 bits)
//  m_*     | out | m_tvalid & m_tready        | crossing record, tuser dropped, tlast
//  apb     | in  | psel & penable & pwrite    | inverse_map_interval when paddr[2] is 0
//
// One item is accepted, then the three velocities are computed, then per image and
// endpoint there are three squarings, a square root and a slice scaling, plus one
// decision step per image and one step per emitted record, all on one serial
// multiplier and one serial square-root unit.
// Reset is asynchronous; the block takes a new item only when the previous one has
// delivered its last record. A stalled output holds its record and the sequencer.
module light_cone_crossing_finder_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,  // start_x,y,z, end_x,y,z, step_time, step_length, step_length_inverse
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [215:0] m_tdata,  // slice_index, image_number, pos_x,y,z, vel_x,y,z
    output logic         m_tuser,  // dropped_flag
    output logic         m_tlast,  // last_record
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lccf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_VEL   = 12'b000000000010,
        S_SQ    = 12'b000000000100,
        S_SQRT  = 12'b000000001000,
        S_SL    = 12'b000000010000,
        S_DEC   = 12'b000000100000,
        S_EMIT  = 12'b000001000000,
        S_NEXT  = 12'b000010000000,
        S_FIN   = 12'b000100000000,
        S_WAIT  = 12'b001000000000,
        S_START = 12'b010000000000,
        S_SQGO  = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    logic [31:0] inv_reg;
    logic [31:0] vel_reg [3];
    logic [31:0] pos_reg [3];
    logic [1:0]  ax_reg;       // axis / phase counter
    logic        ep_reg;       // endpoint 0 start, 1 end
    logic [ImgW:0] img_reg;
    logic [SumW-1:0] sum_reg;
    logic        inr_reg;      // either endpoint within unit radius
    logic [33:0] i0_reg, i1_reg;
    logic [33:0] cur_reg;
    logic [3:0]  cnt_reg;
    logic        drop_reg;

    // output register with pending record (for last marking)
    logic        ov_reg, ov_next;
    out_item_t   ob_reg;
    logic        od_reg, ol_reg;
    logic        hv_reg;       // held record waiting to know whether it is last
    out_item_t   hb_reg;
    logic        hd_reg;

    // multiplier
    logic        mul_start, mul_done;
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] mul_p;
    logic        sq_start, sq_done;
    logic [63:0] sq_in;
    logic [31:0] sq_out;

    lccf_serial_mul u_mul (.clk, .rst_n, .start(mul_start), .mcand(mul_a),
                           .mplier(mul_b), .done(mul_done), .product(mul_p));
    lccf_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_in),
                      .done(sq_done), .root(sq_out));

    logic signed [32:0] diff;
    logic signed [33:0] shifted;
    logic [32:0] diff_mag;
    logic [32:0] sh_mag;
    logic [31:0] sh_mag32;
    logic [33:0] t_sel;
    logic [33:0] i_new;
    logic [31:0] vmag;
    logic [31:0] vsig;
    logic        out_free;
    logic        rec_push;
    logic        emit_ok;
    logic [15:0] sl_full;

    logic signed [31:0] s_ax, e_ax;
    always_comb
    begin
        case (ax_reg)
            2'd0:    begin s_ax = item_reg.start_x; e_ax = item_reg.end_x; end
            2'd1:    begin s_ax = item_reg.start_y; e_ax = item_reg.end_y; end
            default: begin s_ax = item_reg.start_z; e_ax = item_reg.end_z; end
        endcase
    end

    assign diff     = 33'(e_ax) - 33'(s_ax);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign shifted  = 34'(ep_reg ? e_ax : s_ax)
                    - (img_reg[ax_reg] ? 34'sd1 <<< FracBits : 34'sd0);
    assign sh_mag   = shifted[33] ? 33'(-shifted) : 33'(shifted);
    assign sh_mag32 = sh_mag[31:0];
    // The root is still held by the square-root unit when its done pulse arrives.
    assign t_sel    = ep_reg ? 34'(item_reg.step_time) + 34'(item_reg.step_length)
                                 + 34'(sq_out)
                             : 34'(item_reg.step_time) + 34'(sq_out);
    assign i_new    = mul_p[65:32];

    always_comb
    begin
        logic [49:0] pv;
        pv = mul_p[65:16];
        if (pv > 50'h80000000)
            vmag = 32'h80000000;
        else
            vmag = pv[31:0];
        vsig = diff[32] ? 32'(-vmag) : vmag;
        if (!diff[32] && vmag == 32'h80000000)
            vsig = 32'h7FFFFFFF;
    end

    always_comb
    begin
        logic [SumW-1:0] s;
        s = sum_reg >> SqrtShift;
        if ((sum_reg >> (SqrtShift + 64)) != '0)
            sq_in = '1;
        else
            sq_in = s[63:0];
    end

    assign out_free = !ov_reg || m_tready;
    assign sl_full  = 16'(cur_reg + 34'd1 > 34'd65535 ? 34'd65535 : cur_reg + 34'd1);
    assign emit_ok  = !hv_reg || out_free;

    // The shifted magnitude stays below 2^32, so multiplying it by its low 32 bits
    // gives the whole square.
    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sq_start   = 1'b0;
        state_next = state_reg;
        rec_push   = 1'b0;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_START;
            S_START: begin
                mul_start = 1'b1;
                mul_a = 34'(diff_mag);
                mul_b = item_reg.step_length_inverse;
                state_next = S_VEL;
            end
            S_VEL: if (mul_done) state_next = (ax_reg == 2'd2) ? S_NEXT : S_START;
            S_NEXT: begin
                if (img_reg[ImgW]) state_next = S_FIN;
                else
                begin
                    mul_start = 1'b1;
                    mul_a = 34'(sh_mag);
                    mul_b = sh_mag32;
                    state_next = S_SQ;
                end
            end
            S_SQ: if (mul_done) state_next = S_SQGO;
            S_SQGO: begin
                // The axis counter wraps to zero once all three squares are summed.
                if (ax_reg == 2'd0)
                begin
                    sq_start = 1'b1;
                    state_next = S_SQRT;
                end
                else
                begin
                    mul_start = 1'b1;
                    mul_a = 34'(sh_mag);
                    mul_b = sh_mag32;
                    state_next = S_SQ;
                end
            end
            S_SQRT: if (sq_done)
            begin
                mul_start = 1'b1;
                mul_a = t_sel;
                mul_b = inv_reg;
                state_next = S_SL;
            end
            S_SL: if (mul_done)
            begin
                if (!ep_reg) state_next = S_NEXT;
                else state_next = S_DEC;
            end
            S_DEC: state_next = (inr_reg && i1_reg > i0_reg) ? S_EMIT : S_NEXT;
            S_EMIT: if (emit_ok)
            begin
                rec_push = 1'b1;
                if (cnt_reg == 4'd1 || cur_reg + 34'd1 == i1_reg) state_next = S_NEXT;
            end
            S_FIN: if (!hv_reg || out_free) state_next = S_WAIT;
            S_WAIT: if (!ov_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        if ((rec_push && hv_reg) || (state_reg == S_FIN && hv_reg && out_free))
            ov_next = 1'b1;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            inv_reg   <= InvIntervalReset;
            ov_reg    <= 1'b0;
            hv_reg    <= 1'b0;
            ax_reg    <= '0;
            ep_reg    <= 1'b0;
            img_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (psel && penable && pwrite && paddr[2] == AddrInvInterval)
                inv_reg <= pwdata;
            case (state_reg)
                S_IDLE: if (s_tvalid)
                begin
                    ax_reg  <= '0;
                    img_reg <= '0;
                    ep_reg  <= 1'b0;
                end
                S_VEL: if (mul_done)
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                S_SQ: if (mul_done)
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                S_SL: if (mul_done)
                begin
                    if (!ep_reg) ep_reg <= 1'b1;
                    else ep_reg <= 1'b0;
                end
                S_DEC: if (!(inr_reg && i1_reg > i0_reg)) img_reg <= img_reg + 1'b1;
                S_EMIT: if (emit_ok)
                begin
                    hv_reg <= 1'b1;
                    if (cnt_reg == 4'd1 || cur_reg + 34'd1 == i1_reg)
                        img_reg <= img_reg + 1'b1;
                end
                S_FIN: if (hv_reg && out_free)
                    hv_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE: if (s_tvalid) item_reg <= in_item_t'(s_tdata);
            S_VEL: if (mul_done) vel_reg[ax_reg] <= vsig;
            S_NEXT:
            begin
                sum_reg <= '0;
                if (!ep_reg) inr_reg <= 1'b0;
            end
            S_SQ: if (mul_done)
            begin
                logic [SumW-1:0] sq;
                sq = mul_p;
                sum_reg <= sum_reg + sq;
                if (!ep_reg) pos_reg[ax_reg] <= sat32(shifted);
                if (ax_reg == 2'd2)
                begin
                    logic [SumW-1:0] tot;
                    tot = sum_reg + sq;
                    if (tot <= (66'd1 << (2 * FracBits))) inr_reg <= 1'b1;
                end
            end
            S_SL: if (mul_done)
            begin
                if (!ep_reg) i0_reg <= i_new;
                else i1_reg <= i_new;
            end
            S_DEC:
            begin
                cur_reg  <= i0_reg;
                drop_reg <= (i1_reg - i0_reg) > 34'(MaxCrossings);
                cnt_reg  <= 4'(MaxCrossings);
            end
            S_EMIT: if (emit_ok)
            begin
                hb_reg.slice_index  <= sl_full;
                hb_reg.image_number <= img_reg[ImgW-1:0];
                hb_reg.pos_x <= pos_reg[0];
                hb_reg.pos_y <= pos_reg[1];
                hb_reg.pos_z <= pos_reg[2];
                hb_reg.vel_x <= vel_reg[0];
                hb_reg.vel_y <= vel_reg[1];
                hb_reg.vel_z <= vel_reg[2];
                hd_reg  <= drop_reg;
                cur_reg <= cur_reg + 34'd1;
                cnt_reg <= cnt_reg - 4'd1;
                if (hv_reg)
                begin
                    ob_reg <= hb_reg;
                    od_reg <= hd_reg;
                    ol_reg <= 1'b0;
                end
            end
            S_FIN: if (hv_reg && out_free)
            begin
                ob_reg <= hb_reg;
                od_reg <= hd_reg;
                ol_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, ob_reg};
    assign m_tuser  = od_reg;
    assign m_tlast  = ol_reg;
    assign prdata   = inv_reg;
    assign pready   = 1'b1;
endmodule
